### hw/rtl/tsh_pkg.sv
// ----------------------------------------------------------------------------
// tsh_pkg
// Shared types and constants for the TCP SYN header builder.
// ----------------------------------------------------------------------------
package tsh_pkg;

  localparam int unsigned NumWords = 10;
  localparam int unsigned IdxW     = $clog2(NumWords);

  localparam logic [IdxW-1:0] LastIdx = IdxW'(NumWords - 1);

  localparam logic [7:0]  DefaultTtl     = 8'd64;
  localparam logic [7:0]  ProtoTcp       = 8'd6;
  localparam logic [15:0] TcpHdrLen      = 16'd20;
  localparam logic [15:0] TotalLen       = 16'd40;
  localparam logic [15:0] WindowSize     = 16'hFFFF;
  localparam logic [15:0] SynOffsetFlags = 16'h5002;
  localparam logic [7:0]  VerIhl         = 8'h45;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CfgSrcAddr = 2'd0,
    CfgDstAddr = 2'd1,
    CfgTtl     = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] src_port;
    logic [15:0] target_port;
    logic [15:0] ip_ident;
    logic [31:0] sequence_number;
  } probe_t;

endpackage

### hw/rtl/tsh_csum.sv
// ----------------------------------------------------------------------------
// tsh_csum
// TCP checksum over pseudo-header and SYN header, folded and inverted.
// ----------------------------------------------------------------------------
module tsh_csum (
  input  logic [31:0]   src_addr_i,
  input  logic [31:0]   dst_addr_i,
  input  tsh_pkg::probe_t probe_i,
  output logic [15:0]   csum_o
);

  // Fixed terms: protocol, TCP length, offset/flags, window
  localparam logic [19:0] FixedSum = 20'({8'd0, tsh_pkg::ProtoTcp})
                                   + 20'(tsh_pkg::TcpHdrLen)
                                   + 20'(tsh_pkg::SynOffsetFlags)
                                   + 20'(tsh_pkg::WindowSize);

  logic [19:0] acc;
  logic [16:0] fold1;
  logic [15:0] fold2;

  // Twelve 16-bit terms stay below 2^20
  assign acc = FixedSum
             + 20'(src_addr_i[31:16]) + 20'(src_addr_i[15:0])
             + 20'(dst_addr_i[31:16]) + 20'(dst_addr_i[15:0])
             + 20'(probe_i.src_port) + 20'(probe_i.target_port)
             + 20'(probe_i.sequence_number[31:16])
             + 20'(probe_i.sequence_number[15:0]);

  // Two end-around carry folds reach a 16-bit value
  assign fold1  = 17'(acc[15:0]) + 17'(acc[19:16]);
  assign fold2  = fold1[15:0] + 16'(fold1[16]);
  assign csum_o = ~fold2;

endmodule

### hw/rtl/tsh_serializer.sv
// ----------------------------------------------------------------------------
// tsh_serializer
// Holds one probe and streams its ten header words through an output register.
// ----------------------------------------------------------------------------
module tsh_serializer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  tsh_pkg::probe_t       probe_i,
  input  logic [15:0]           csum_i,
  input  logic [31:0]           src_addr_i,
  input  logic [31:0]           dst_addr_i,
  input  logic [7:0]            ttl_i,
  output logic                  ready_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           packet_word_o,
  output logic                  last_word_o
);

  logic                     busy_q;
  logic [tsh_pkg::IdxW-1:0] idx_q;
  tsh_pkg::probe_t          probe_q;
  logic [15:0]              csum_q;
  logic                     out_valid_q;
  logic [31:0]              word_q;
  logic                     last_q;

  logic                     out_free;
  logic [31:0]              word_d;
  logic [7:0]               ttl_eff;

  assign out_free = !out_valid_q || !out_stall_i;
  assign ready_o  = !busy_q || (out_free && (idx_q == tsh_pkg::LastIdx));
  assign ttl_eff  = (ttl_i == 8'd0) ? tsh_pkg::DefaultTtl : ttl_i;

  always_comb begin
    case (idx_q)
      4'd0:    word_d = {tsh_pkg::VerIhl, 8'd0, tsh_pkg::TotalLen};
      4'd1:    word_d = {probe_q.ip_ident, 16'd0};
      4'd2:    word_d = {ttl_eff, tsh_pkg::ProtoTcp, 16'd0};
      4'd3:    word_d = src_addr_i;
      4'd4:    word_d = dst_addr_i;
      4'd5:    word_d = {probe_q.src_port, probe_q.target_port};
      4'd6:    word_d = probe_q.sequence_number;
      4'd7:    word_d = 32'd0;
      4'd8:    word_d = {tsh_pkg::SynOffsetFlags, tsh_pkg::WindowSize};
      default: word_d = {csum_q, 16'd0};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= busy_q;
        if (busy_q) begin
          idx_q <= idx_q + tsh_pkg::IdxW'(1);
          if (idx_q == tsh_pkg::LastIdx) begin
            busy_q <= 1'b0;
          end
        end
      end
      if (load_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && busy_q) begin
      word_q <= word_d;
      last_q <= (idx_q == tsh_pkg::LastIdx);
    end
    if (load_i) begin
      probe_q <= probe_i;
      csum_q  <= csum_i;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packet_word_o = word_q;
  assign last_word_o   = last_q;

endmodule

### hw/rtl/tcp_syn_header_builder.sv
// ----------------------------------------------------------------------------
// tcp_syn_header_builder
// Builds a 40-byte IPv4 + TCP SYN header per probe, as ten 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one probe item: source
//   port, target port, IP identification and sequence number. Output channel
//   (out_valid_o / out_stall_i) returns ten big-endian header words per item,
//   first byte in the top bits; last_word_o marks the tenth word.
//   Configuration: source/destination address and TTL through cfg_we_i,
//   cfg_index_i, cfg_data_i. TTL 0 means 64. Write only while idle.
// Path: input register, serializer hold register, then the output word register.
// Overlap: the single output word port limits the item rate; the next item
//   waits in the input register while words stream out.
// Reset: all channels go empty, addresses clear to 0 and TTL returns to 64.
// Stall: a stalled output word holds; the serializer freezes, and once the
//   input register is full in_stall_o rises until the serializer drains.
// ----------------------------------------------------------------------------
module tcp_syn_header_builder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration
  input  logic                         cfg_we_i,
  input  logic [tsh_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tsh_pkg::CfgDataW-1:0] cfg_data_i,
  // probe items
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [15:0]                  src_port_i,
  input  logic [15:0]                  target_port_i,
  input  logic [15:0]                  ip_ident_i,
  input  logic [31:0]                  sequence_number_i,
  // header words
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [31:0]                  packet_word_o,
  output logic                         last_word_o
);

  logic [31:0]     src_addr_q;
  logic [31:0]     dst_addr_q;
  logic [7:0]      ttl_q;

  logic            in_valid_q;
  tsh_pkg::probe_t probe_q;
  logic            ser_ready;
  logic            take;
  logic            accept;
  logic [15:0]     csum;

  // Register decode; out-of-range indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_addr_q <= '0;
      dst_addr_q <= '0;
      ttl_q      <= tsh_pkg::DefaultTtl;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        tsh_pkg::CfgSrcAddr: src_addr_q <= cfg_data_i;
        tsh_pkg::CfgDstAddr: dst_addr_q <= cfg_data_i;
        tsh_pkg::CfgTtl:     ttl_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // Input register: hand off to the serializer when it can load
  assign take       = in_valid_q && ser_ready;
  assign in_stall_o = in_valid_q && !ser_ready;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (take) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      probe_q.src_port        <= src_port_i;
      probe_q.target_port     <= target_port_i;
      probe_q.ip_ident        <= ip_ident_i;
      probe_q.sequence_number <= sequence_number_i;
    end
  end

  // Checksum sits between the input register and the serializer hold register
  tsh_csum u_csum (
    .src_addr_i (src_addr_q),
    .dst_addr_i (dst_addr_q),
    .probe_i    (probe_q),
    .csum_o     (csum)
  );

  tsh_serializer u_serializer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take),
    .probe_i       (probe_q),
    .csum_i        (csum),
    .src_addr_i    (src_addr_q),
    .dst_addr_i    (dst_addr_q),
    .ttl_i         (ttl_q),
    .ready_o       (ser_ready),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .packet_word_o (packet_word_o),
    .last_word_o   (last_word_o)
  );

endmodule
